FILE: hdl/sorted_table_key_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table key search block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_KEY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_KEY_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a condition implies a property in the same cycle.
`define STS_ASSERT_IMPL(lbl, clk_s, rst_s, cond, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (prop)) \
    else $error(msg);
// Check that a condition implies a property in the next cycle.
`define STS_ASSERT_NEXT(lbl, clk_s, rst_s, cond, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (prop)) \
    else $error(msg);
`else
`define STS_ASSERT_IMPL(lbl, clk_s, rst_s, cond, prop, msg)
`define STS_ASSERT_NEXT(lbl, clk_s, rst_s, cond, prop, msg)
`endif

`endif

FILE: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table key search package
// Widths, table depth and codes shared by the interfaces and the block.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Table depth and the index width that follows from it.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int ADDR_W   = 10;
  localparam int KEY_W    = 32;
  localparam int ROW_W    = 10;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  // Search pointers need room for a hunt that overshoots either end.
  localparam int PTR_W = CNT_W + 2;

  // Item kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT  = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

endpackage

FILE: hdl/sts_item_if.sv
// ----------------------------------------------------------------------------
// Sorted table key search input channel
// Carries one load or search word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_item_if;
  import sts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [ADDR_W-1:0]       entry_address;
  logic signed [KEY_W-1:0] key_value;
  logic [ROW_W-1:0]        row_number;

  modport source (output valid, output mode, output entry_address,
                  output key_value, output row_number, input ready);
  modport sink   (input valid, input mode, input entry_address,
                  input key_value, input row_number, output ready);
endinterface

FILE: hdl/sts_result_if.sv
// ----------------------------------------------------------------------------
// Sorted table key search result channel
// Carries one search result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_result_if;
  import sts_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   position;
  logic [ROW_W-1:0]    matched_row;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output position, output matched_row,
                  output status, input ready);
  modport sink   (input valid, input position, input matched_row,
                  input status, output ready);
endinterface

FILE: hdl/sorted_table_key_search.sv
// ----------------------------------------------------------------------------
// Sorted table key search
// Stores a monotonic key table with row numbers and finds the last key
// that does not pass a search key, by hunting from the last hit and bisecting.
// ----------------------------------------------------------------------------
// Usage: words arrive on the item channel. A load word (mode 0) writes one
// key and row number into the table and produces no result. A search word
// (mode 1) produces one word on the result channel with the found position,
// the row number stored there and a status code.
// The entry count register is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Counts of zero or above the depth are clamped. A load is written into
// the table from the idle state, which it does not leave. A search goes through
// one synchronous table read port: it reads the first and last keys, hunts
// outward from the last hit, then bisects; each probe is a *_CHK state issuing
// the read and an *_EVAL state seeing it. The item channel is ready only while
// the sequencer is idle, so no new word is taken until a search is done.
// A finished result sits in an output register, so the block takes new words
// while the receiver stalls; only when a second search finishes before the
// first result is taken does the sequencer wait with the result in hand.
// Reset clears the search hint to zero, the entry count to one and the result
// valid flag; the table itself holds whatever was last written.
// ----------------------------------------------------------------------------
`include "sorted_table_key_search_defines.svh"

module sorted_table_key_search (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [sts_pkg::CNT_W-1:0] cfg_wdata,
  sts_item_if.sink                 item,
  sts_result_if.source             result
);
  import sts_pkg::*;

  typedef logic signed [PTR_W-1:0] ptr_t;

  // Sequencer states. Each *_CHK state decides whether to issue a table read,
  // the matching *_EVAL state sees the registered read data.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_DOWN_CHK,
    S_DOWN_EVAL,
    S_UP_CHK,
    S_UP_EVAL,
    S_BIS_CHK,
    S_BIS_EVAL,
    S_RES
  } state_t;

  // True when key k has not passed x in the table direction.
  function automatic logic not_past(input logic asc_f,
                                    input logic signed [KEY_W-1:0] k,
                                    input logic signed [KEY_W-1:0] x);
    return asc_f ? (k <= x) : (k >= x);
  endfunction

  // Table storage, one write and one registered read per cycle.
  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [ROW_W-1:0]        row_mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rd_key;
  logic [ROW_W-1:0]        rd_row;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;

  // Control and datapath registers.
  state_t                  state, state_next;
  logic [CNT_W-1:0]        entry_count;
  logic [ADDR_W-1:0]       last_position, last_position_next;
  logic [CNT_W-1:0]        n_s, n_next;
  logic signed [KEY_W-1:0] x_s, x_next;
  logic signed [KEY_W-1:0] key0, key0_next;
  logic signed [KEY_W-1:0] keyn, keyn_next;
  logic                    asc, asc_next;
  ptr_t                    lo, lo_next;
  ptr_t                    hi, hi_next;
  ptr_t                    step, step_next;
  ptr_t                    mid, mid_next;
  logic                    out_valid, out_valid_next;
  logic [ADDR_W-1:0]       out_pos, out_pos_next;
  logic [ROW_W-1:0]        out_row, out_row_next;
  status_t                 out_status, out_status_next;

  ptr_t n_ptr;
  assign n_ptr = $signed({2'b00, n_s});

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.position    = out_pos;
  assign result.matched_row = out_row;
  assign result.status      = out_status;

  always_comb begin
    logic [CNT_W-1:0] n_c;
    logic [CNT_W-1:0] hint;
    ptr_t             sum;

    state_next         = state;
    last_position_next = last_position;
    n_next             = n_s;
    x_next             = x_s;
    key0_next          = key0;
    keyn_next          = keyn;
    asc_next           = asc;
    lo_next            = lo;
    hi_next            = hi;
    step_next          = step;
    mid_next           = mid;
    out_valid_next     = out_valid && !result.ready;
    out_pos_next       = out_pos;
    out_row_next       = out_row;
    out_status_next    = out_status;
    rd_addr            = '0;
    mem_we             = 1'b0;
    n_c                = entry_count;
    hint               = {1'b0, last_position};
    sum                = lo + hi;

    if (entry_count == '0) begin
      n_c = CNT_W'(1);
    end else if (int'(entry_count) > TABLE_DEPTH) begin
      n_c = CNT_W'(TABLE_DEPTH);
    end
    if (hint >= n_c) begin
      hint = n_c - CNT_W'(1);
    end

    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          if (item.mode == MODE_SEARCH) begin
            n_next     = n_c;
            x_next     = item.key_value;
            lo_next    = $signed({2'b00, hint});
            hi_next    = $signed({2'b00, hint}) + ptr_t'(1);
            step_next  = ptr_t'(1);
            rd_addr    = '0;
            state_next = S_FIRST;
          end else begin
            mem_we = (int'(item.entry_address) < TABLE_DEPTH);
          end
        end
      end
      S_FIRST: begin
        key0_next  = rd_key;
        rd_addr    = IDX_W'(n_s - CNT_W'(1));
        state_next = S_LAST;
      end
      S_LAST: begin
        keyn_next  = rd_key;
        asc_next   = (rd_key > key0);
        state_next = S_DOWN_CHK;
      end
      S_DOWN_CHK: begin
        if (lo > ptr_t'(0)) begin
          rd_addr    = lo[IDX_W-1:0];
          state_next = S_DOWN_EVAL;
        end else begin
          lo_next    = ptr_t'(0);
          state_next = S_UP_CHK;
        end
      end
      S_DOWN_EVAL: begin
        if (!not_past(asc, rd_key, x_s)) begin
          hi_next    = lo;
          lo_next    = lo - step;
          step_next  = step <<< 1;
          state_next = S_DOWN_CHK;
        end else begin
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (hi < n_ptr) begin
          rd_addr    = hi[IDX_W-1:0];
          state_next = S_UP_EVAL;
        end else begin
          hi_next    = n_ptr;
          state_next = S_BIS_CHK;
        end
      end
      S_UP_EVAL: begin
        if (not_past(asc, rd_key, x_s)) begin
          lo_next    = hi;
          hi_next    = hi + step;
          step_next  = step <<< 1;
          state_next = S_UP_CHK;
        end else begin
          state_next = S_BIS_CHK;
        end
      end
      S_BIS_CHK: begin
        mid_next = sum >>> 1;
        if ((sum >>> 1) != lo) begin
          rd_addr    = mid_next[IDX_W-1:0];
          state_next = S_BIS_EVAL;
        end else begin
          rd_addr    = lo[IDX_W-1:0];
          state_next = S_RES;
        end
      end
      S_BIS_EVAL: begin
        if (not_past(asc, rd_key, x_s)) begin
          lo_next = mid;
        end else begin
          hi_next = mid;
        end
        state_next = S_BIS_CHK;
      end
      S_RES: begin
        // Keep the read address on the found position while waiting.
        rd_addr = lo[IDX_W-1:0];
        if (!out_valid || result.ready) begin
          out_valid_next     = 1'b1;
          out_pos_next       = lo[ADDR_W-1:0];
          out_row_next       = rd_row;
          last_position_next = lo[ADDR_W-1:0];
          if (x_s < key0) begin
            out_status_next = ST_BELOW;
          end else if (x_s > keyn) begin
            out_status_next = ST_ABOVE;
          end else if (rd_key == x_s) begin
            out_status_next = ST_EXACT;
          end else begin
            out_status_next = ST_ABSENT;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[IDX_W'(item.entry_address)] <= item.key_value;
      row_mem[IDX_W'(item.entry_address)] <= item.row_number;
    end
    rd_key <= key_mem[rd_addr];
    rd_row <= row_mem[rd_addr];
  end

  // Sequencer state, datapath and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= CNT_W'(1);
      last_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      last_position <= last_position_next;
      out_valid     <= out_valid_next;
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
    end
    n_s        <= n_next;
    x_s        <= x_next;
    key0       <= key0_next;
    keyn       <= keyn_next;
    asc        <= asc_next;
    lo         <= lo_next;
    hi         <= hi_next;
    step       <= step_next;
    mid        <= mid_next;
    out_pos    <= out_pos_next;
    out_row    <= out_row_next;
    out_status <= out_status_next;
  end

  // The bracket stays open while bisecting.
  `STS_ASSERT_IMPL(a_bracket_open, clk, rst, state == S_BIS_CHK, lo < hi,
    "search bracket closed before bisection")
  // A bisection probe lies inside the table and the bracket.
  `STS_ASSERT_IMPL(a_mid_inside, clk, rst, state == S_BIS_EVAL,
    (mid >= lo) && (mid < hi) && (mid >= ptr_t'(0)),
    "bisection probe outside the bracket")
  // A downward hunt probe reads a real table entry.
  `STS_ASSERT_IMPL(a_down_probe, clk, rst, state == S_DOWN_EVAL,
    (lo > ptr_t'(0)) && (lo < n_ptr), "downward hunt probe out of range")
  // The hunt step is always a power of two during a search.
  `STS_ASSERT_IMPL(a_step_pow2, clk, rst, state != S_IDLE, $onehot(step),
    "hunt step is not a power of two")
  // A completed search always leaves a pending result behind.
  `STS_ASSERT_NEXT(a_res_loads, clk, rst,
    (state == S_RES) && (!out_valid || result.ready), out_valid && (state == S_IDLE),
    "finished search did not load the result register")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sorted table key search regression
// Loads key tables of many sizes, mostly monotonic, searches them with exact,
// in-between and out-of-range keys, and checks every result word against a
// hunt-and-bisection predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
module testbench;
  import sts_pkg::*;

  // Extreme key values, written as bit patterns so they land in a signed int.
  localparam int KEY_MIN = 32'h8000_0000;
  localparam int KEY_MAX = 32'h7FFF_FFFF;

  // Cycles the receiver refuses results when the long hold-off is requested.
  localparam int HOLDOFF_CYCLES = 300;
  // Quiet cycles before an entry count write, so a trailing load has landed.
  localparam int SETTLE_CYCLES = 16;
  // Cycles watched after the last expected word, in case a stray word shows up.
  localparam int DRAIN_CYCLES = 100;
  // Number of table settings in the random part.
  localparam int NUM_PHASES = 14;
  // Size of the one large table, and the smaller count that reuses it.
  localparam int BIG_COUNT  = 256;
  localparam int KEEP_COUNT = 200;

  // One expected result word.
  typedef struct {
    logic [ADDR_W-1:0] position;
    logic [ROW_W-1:0]  matched_row;
    status_t           status;
  } search_result_t;

  // The checker keeps its own copy of the table, the entry count and the
  // search hint. Every accepted input word is applied to that copy in order;
  // a search word leaves one expected result in the queue.
  class search_result_checker;
    int               key_tab [TABLE_DEPTH];
    bit [ROW_W-1:0]   row_tab [TABLE_DEPTH];
    int               hint;
    logic [CNT_W-1:0] count_reg;
    search_result_t   pending_lookups [$];
    int               errors;
    int               searches_checked;

    function new();
      hint             = 0;
      count_reg        = CNT_W'(1);
      errors           = 0;
      searches_checked = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      count_reg = value;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    // Counts of zero act as one, counts above the depth act as the depth.
    function int active_entries();
      if (count_reg < 1)
        return 1;
      if (count_reg > TABLE_DEPTH)
        return TABLE_DEPTH;
      return int'(count_reg);
    endfunction

    // True when key k has not yet passed x in the direction of the table.
    function bit not_passed(bit ascending, int k, int x);
      return ascending ? (k <= x) : (k >= x);
    endfunction

    // Hunt outward from the hint with doubling steps, then bisect.
    function int hunt_position(int n, int x);
      int lo;
      int hi;
      int mid;
      int step;
      bit ascending;
      step      = 1;
      ascending = key_tab[n-1] > key_tab[0];
      lo        = hint;
      if (lo < 0)
        lo = 0;
      if (lo >= n)
        lo = n - 1;
      hi = lo + 1;
      while (lo > 0 && !not_passed(ascending, key_tab[lo], x)) begin
        hi   = lo;
        lo   = lo - step;
        step = step + step;
      end
      if (lo < 0)
        lo = 0;
      while (hi < n && not_passed(ascending, key_tab[hi], x)) begin
        lo   = hi;
        hi   = hi + step;
        step = step + step;
      end
      if (hi > n)
        hi = n;
      mid = (lo + hi) >> 1;
      while (mid != lo) begin
        if (not_passed(ascending, key_tab[mid], x))
          lo = mid;
        else
          hi = mid;
        mid = (lo + hi) >> 1;
      end
      return lo;
    endfunction

    function void note_word(logic mode, logic [ADDR_W-1:0] addr,
                            logic signed [KEY_W-1:0] key, logic [ROW_W-1:0] row);
      int             n;
      int             pos;
      int             x;
      search_result_t res;
      x = key;
      if (mode == MODE_LOAD) begin
        // Every 10-bit address lies inside the table, so a load always lands.
        key_tab[addr] = x;
        row_tab[addr] = row;
        return;
      end
      n    = active_entries();
      pos  = hunt_position(n, x);
      hint = pos;
      // The plain comparisons apply to descending tables as well.
      if (x < key_tab[0])
        res.status = ST_BELOW;
      else if (x > key_tab[n-1])
        res.status = ST_ABOVE;
      else if (key_tab[pos] == x)
        res.status = ST_EXACT;
      else
        res.status = ST_ABSENT;
      res.position    = pos[ADDR_W-1:0];
      res.matched_row = row_tab[pos];
      pending_lookups.push_back(res);
    endfunction

    function void check_result(logic [ADDR_W-1:0] position,
                               logic [ROW_W-1:0] matched_row,
                               logic [STATUS_W-1:0] status);
      search_result_t exp;
      if (pending_lookups.size() == 0) begin
        $error("result word with no search outstanding: position %0d", position);
        errors++;
        return;
      end
      exp = pending_lookups.pop_front();
      searches_checked++;
      if (position !== exp.position) begin
        $error("position mismatch: expected %0d, actual %0d", exp.position, position);
        errors++;
      end
      if (matched_row !== exp.matched_row) begin
        $error("matched_row mismatch: expected %0d, actual %0d",
               exp.matched_row, matched_row);
        errors++;
      end
      if (status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  sts_item_if   item_ch ();
  sts_result_if result_ch ();

  sorted_table_key_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  search_result_checker results_check;

  // Idle percentages of the two sides, changed between phases by the
  // stimulus process, and the request for one long receiver hold-off.
  int src_idle_pct = 29;
  int snk_idle_pct = 79;
  bit holdoff_req  = 1'b0;

  // Key of every table position as last loaded; used only to choose
  // interesting search keys.
  int shadow_key [TABLE_DEPTH];

  int loads_sent    = 0;
  int settings_made = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are taken at the rising edge, with the values that the block
  // presented before that edge.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      results_check.check_result(result_ch.position, result_ch.matched_row,
                                 result_ch.status);
  end

  // The receiver drops ready at random, and once holds it low for a long
  // stretch so the output register fills and the block stops taking words.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        result_ch.ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_req = 1'b0;
      end
      result_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one word. The sender may first idle at random; valid then
  // stays high until the block takes the word. Valid is left high afterwards,
  // so back-to-back words never see it drop and rise in one step.
  task automatic send_word(logic mode, logic [ADDR_W-1:0] addr, int key,
                           logic [ROW_W-1:0] row);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid         = 1'b1;
    item_ch.mode          = mode;
    item_ch.entry_address = addr;
    item_ch.key_value     = key;
    item_ch.row_number    = row;
    do @(posedge clk); while (!item_ch.ready);
    results_check.note_word(mode, addr, key, row);
  endtask

  task automatic load_entry(int addr, int key, int row);
    shadow_key[addr] = key;
    loads_sent++;
    send_word(MODE_LOAD, addr[ADDR_W-1:0], key, row[ROW_W-1:0]);
  endtask

  // The address and row fields of a search are ignored, so they carry noise.
  task automatic find_key(int key);
    send_word(MODE_SEARCH, ADDR_W'($urandom_range(TABLE_DEPTH-1)), key,
              ROW_W'($urandom_range(TABLE_DEPTH-1)));
  endtask

  // The entry count may only change while the block is idle: no word on
  // offer, every result delivered, and a few cycles for a trailing load.
  task automatic write_entry_count(logic [CNT_W-1:0] value);
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (results_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    results_check.set_count(value);
    settings_made++;
  endtask

  function automatic int clamp_key(longint v);
    if (v < longint'(KEY_MIN))
      return KEY_MIN;
    if (v > longint'(KEY_MAX))
      return KEY_MAX;
    return int'(v);
  endfunction

  // Search keys: extremes, stored keys, their neighbors, keys just outside
  // both ends of the table, and plain random values.
  function automatic int pick_search_key(int n);
    int pick;
    int stored;
    pick   = $urandom_range(9);
    stored = shadow_key[$urandom_range(n - 1)];
    case (pick)
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3: return int'($urandom);
      4, 5, 6: return stored;
      7: return clamp_key(longint'(stored) + ($urandom_range(1) ? 1 : -1));
      8: return clamp_key(longint'(shadow_key[0]) - 1);
      default: return clamp_key(longint'(shadow_key[n-1]) + 1);
    endcase
  endfunction

  initial begin
    int               p;
    int               i;
    int               n;
    int               n_search;
    int               style;
    bit               ascending;
    logic [CNT_W-1:0] count_value;
    int               table_keys [$];

    results_check = new();

    // Every input is known from time zero.
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    item_ch.valid         = 1'b0;
    item_ch.mode          = MODE_LOAD;
    item_ch.entry_address = '0;
    item_ch.key_value     = '0;
    item_ch.row_number    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. After reset the count is one: a single-entry table is
    // treated as descending, and the hint starts at zero.
    load_entry(0, 100, 1023);
    find_key(100);
    find_key(99);
    find_key(101);
    find_key(KEY_MIN);
    find_key(KEY_MAX);
    // Top address and both key extremes; entry 1023 is not read with n = 1.
    load_entry(1023, KEY_MAX, 0);
    load_entry(1, KEY_MIN, 512);

    // Two entries, descending from 100 down to the smallest key.
    write_entry_count(CNT_W'(2));
    find_key(100);
    find_key(KEY_MIN);
    find_key(0);
    find_key(KEY_MAX);

    // Same count, now ascending across the whole key range.
    load_entry(0, KEY_MIN, 341);
    load_entry(1, KEY_MAX, 682);
    find_key(KEY_MIN);
    find_key(KEY_MAX);
    find_key(0);
    find_key(KEY_MIN + 1);

    // Equal end keys make the table count as descending.
    load_entry(1, KEY_MIN, 5);
    find_key(KEY_MIN);
    find_key(0);

    // Random part. Each phase sets a count, loads a fresh table of that size
    // and searches it. Phase 1 writes a count of zero, phase 4 loads one large
    // table, phase 5 keeps it with a smaller count so the hint may lie beyond
    // the active entries, and phase 9 loads an unsorted table. Small counts
    // after the large table leave the hint far outside the active range.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 5) begin
        src_idle_pct = 29;
        snk_idle_pct = 79;
      end else if (p < 10) begin
        src_idle_pct = 79;
        snk_idle_pct = 29;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      case (p)
        0:       count_value = CNT_W'(1);
        1:       count_value = CNT_W'(0);
        4:       count_value = CNT_W'(BIG_COUNT);
        5:       count_value = CNT_W'(KEEP_COUNT);
        6:       count_value = CNT_W'(2);
        default: count_value = CNT_W'($urandom_range(16, 2));
      endcase
      write_entry_count(count_value);

      if (count_value < 1)
        n = 1;
      else if (count_value > TABLE_DEPTH)
        n = TABLE_DEPTH;
      else
        n = int'(count_value);

      // Phase 5 reuses the large table that phase 4 loaded.
      if (p != 5) begin
        table_keys.delete();
        style     = $urandom_range(2);
        ascending = (p == 4) ? 1'b1 : ($urandom_range(1) != 0);
        for (i = 0; i < n; i++) begin
          if (style == 1)
            table_keys.push_back(int'($urandom_range(15)) - 8);
          else if (style == 2)
            table_keys.push_back(int'($urandom_range(100000)) - 50000);
          else
            table_keys.push_back(int'($urandom));
        end
        if (p != 9) begin
          table_keys.sort();
          if (!ascending)
            table_keys.reverse();
        end
        for (i = 0; i < n; i++)
          load_entry(i, table_keys[i], $urandom_range(TABLE_DEPTH-1));
      end

      // The long hold-off lands at the start of the searches of one phase.
      if (p == 7)
        holdoff_req = 1'b1;

      n_search = (p == 4 || p == 5) ? 20 : $urandom_range(22, 14);
      for (i = 0; i < n_search; i++) begin
        // Now and then a stray load: mostly outside the active entries, but
        // sometimes inside, which breaks the order of the table.
        if ($urandom_range(99) < 8) begin
          if (n < TABLE_DEPTH && $urandom_range(3) != 0)
            load_entry($urandom_range(TABLE_DEPTH-1, n), int'($urandom),
                       $urandom_range(TABLE_DEPTH-1));
          else
            load_entry($urandom_range(n-1), int'($urandom),
                       $urandom_range(TABLE_DEPTH-1));
        end
        find_key(pick_search_key(n));
      end
    end

    // Stop offering, let the last results come out, and watch a while longer.
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (results_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d search results and sent %0d loads over %0d entry count settings,",
             results_check.searches_checked, loads_sent, settings_made);
    $display("with ascending, descending and unsorted tables, counts 0, 1, 2 and up to 256.");
    if (results_check.errors == 0) begin
      $display("sorted_table_key_search regression: pass");
    end else begin
      $display("sorted_table_key_search regression: fail");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin
    #5000000;
    $display("sorted_table_key_search regression: fail");
    $finish;
  end

endmodule
